[hdl/psm_pkg.sv]
package psm_pkg;

  localparam int FRAC_BITS = 16;

  // accumulator: four 64-bit products plus a shifted plane term
  localparam int ACC_W  = 68;
  localparam int NL_W   = 66;
  // normalizer divide: magnitude << FRAC_BITS plus half the length
  localparam int NUM_W  = 32 + FRAC_BITS + 1;
  localparam int DCNT_W = $clog2(NUM_W + 1);

  localparam logic [1:0] REG_PLANE_A = 2'd0;
  localparam logic [1:0] REG_PLANE_B = 2'd1;
  localparam logic [1:0] REG_PLANE_C = 2'd2;
  localparam logic [1:0] REG_PLANE_D = 2'd3;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SHIFT = 7'b0000010,
    S_SQ    = 7'b0000100,
    S_SQRT  = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_NL    = 7'b0100000,
    S_DONE  = 7'b1000000
  } prep_state_t;

endpackage

[hdl/planar_shadow_matrix.sv]
// Channel   Signals                                        Direction
// request   in_valid, in_stall, light_x/y/z, light_kind    in
// entry     out_valid, out_stall, entry_index, entry_value,
//           saturated, last_entry                          out
// config    APB: psel, penable, pwrite, paddr, pwdata,
//           prdata, pready                                 in/out
// A point-light request is prepared while the entry stream of the previous
// request is still running, so matrices can follow back to back.
// A directional request runs the serial normalizer first (shift, square,
// square-root and divide steps; the unit vector comes out in Q16.16).
// Entries leave a four-stage pipeline, one per cycle while out_stall is low. rst is synchronous.
// out_stall freezes the entry pipeline while out_valid is high; prep continues until it needs it.
module planar_shadow_matrix (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  light_x,
  input  logic signed [31:0]  light_y,
  input  logic signed [31:0]  light_z,
  input  logic                light_kind,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [3:0]          entry_index,
  output logic signed [31:0]  entry_value,
  output logic                saturated,
  output logic                last_entry,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import psm_pkg::*;

  // configuration
  logic signed [31:0] plane [4];

  assign pready = 1'b1;
  assign prdata = plane[paddr[3:2]];

  always_ff @(posedge clk) begin
    if (rst) begin
      plane[REG_PLANE_A] <= '0;
      plane[REG_PLANE_B] <= 32'(64'd1 << FRAC_BITS);
      plane[REG_PLANE_C] <= '0;
      plane[REG_PLANE_D] <= '0;
    end else if (psel && penable && pwrite && pready) begin
      plane[paddr[3:2]] <= pwdata;
    end
  end

  // input buffer
  logic               buf_full;
  logic signed [31:0] buf_l [3];
  logic               buf_dir;

  assign in_stall = buf_full;

  // prep sequencer
  prep_state_t        state;
  logic signed [31:0] lv [3];
  logic [31:0]        mag [3];
  logic [2:0]         neg;
  logic               dir;
  logic [1:0]         kc;
  logic [63:0]        sum_sq;
  logic [63:0]        rem_sq;
  logic [63:0]        root;
  logic [63:0]        bitr;
  logic [NUM_W-1:0]   num;
  logic [NUM_W-1:0]   quot;
  logic [32:0]        drem;
  logic [DCNT_W-1:0]  dcnt;
  logic signed [NL_W-1:0] nl;

  // emitter
  logic               emit_busy;
  logic               emit_free;
  logic [3:0]         ecnt;
  logic signed [31:0] el [3];
  logic signed [NL_W-1:0] enl;
  logic               edir;

  logic en;
  assign en = !(out_valid && out_stall);

  // launch the next matrix on the cycle the last entry of the current one advances
  assign emit_free = !emit_busy || (ecnt == 4'd15 && en);

  logic [31:0]        len;
  logic [63:0]        sq_prod;
  logic signed [63:0] nl_prod;
  logic [33:0]        dtry;
  logic [32:0]        dshift;

  assign len     = root[31:0];
  assign sq_prod = mag[kc] * mag[kc];
  assign nl_prod = lv[kc] * plane[kc];
  assign dshift  = {drem[31:0], num[NUM_W-1]};
  assign dtry    = {1'b0, dshift} - {2'b00, len};

  // quotient of the component that just finished, before its sign is applied
  logic [31:0] qfin;
  assign qfin = {quot[30:0], !dtry[33]};

  function automatic logic [31:0] abs32(input logic signed [31:0] x);
    abs32 = x[31] ? (~x + 32'd1) : x;
  endfunction

  function automatic logic [NUM_W-1:0] div_num(input logic [31:0] m, input logic [31:0] l);
    div_num = ({{(NUM_W-32){1'b0}}, m} << FRAC_BITS) + {{(NUM_W-32){1'b0}}, 1'b0, l[31:1]};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      buf_full <= 1'b1;
    end else if (state == S_IDLE) begin
      buf_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      buf_l[0] <= light_x;
      buf_l[1] <= light_y;
      buf_l[2] <= light_z;
      buf_dir  <= light_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      emit_busy <= 1'b0;
      ecnt      <= '0;
    end else begin
      if (emit_busy && en) begin
        ecnt <= ecnt + 4'd1;
        if (ecnt == 4'd15) begin
          emit_busy <= 1'b0;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (buf_full) begin
            for (int k = 0; k < 3; k++) begin
              lv[k]  <= buf_l[k];
              mag[k] <= abs32(buf_l[k]);
              neg[k] <= buf_l[k][31];
            end
            dir <= buf_dir;
            kc  <= '0;
            nl  <= '0;
            if (buf_dir && (buf_l[0] != '0 || buf_l[1] != '0 || buf_l[2] != '0)) begin
              state <= S_SHIFT;
            end else begin
              state <= S_NL;
            end
          end
        end
        S_SHIFT: begin
          if ((mag[0][31:30] | mag[1][31:30] | mag[2][31:30]) == 2'b00) begin
            for (int k = 0; k < 3; k++) mag[k] <= mag[k] << 1;
          end else begin
            kc     <= '0;
            sum_sq <= '0;
            state  <= S_SQ;
          end
        end
        S_SQ: begin
          sum_sq <= sum_sq + sq_prod;
          if (kc == 2'd2) begin
            rem_sq <= sum_sq + sq_prod;
            root   <= '0;
            bitr   <= 64'd1 << 62;
            state  <= S_SQRT;
          end else begin
            kc <= kc + 2'd1;
          end
        end
        S_SQRT: begin
          if (rem_sq >= root + bitr) begin
            rem_sq <= rem_sq - (root + bitr);
            root   <= (root >> 1) + bitr;
          end else begin
            root <= root >> 1;
          end
          bitr <= bitr >> 2;
          if (bitr == 64'd1) begin
            kc    <= '0;
            state <= S_DIV;
            dcnt  <= '0;
            drem  <= '0;
            quot  <= '0;
            num   <= div_num(mag[0], (rem_sq >= root + bitr) ? 32'((root >> 1) + bitr)
                                                            : 32'(root >> 1));
          end
        end
        S_DIV: begin
          // restoring divide, one quotient bit per cycle
          num <= num << 1;
          if (!dtry[33]) begin
            drem <= dtry[32:0];
            quot <= {quot[NUM_W-2:0], 1'b1};
          end else begin
            drem <= dshift;
            quot <= {quot[NUM_W-2:0], 1'b0};
          end
          dcnt <= dcnt + 1'b1;
          if (dcnt == DCNT_W'(NUM_W - 1)) begin
            lv[kc] <= neg[kc] ? -$signed(qfin) : $signed(qfin);
            dcnt <= '0;
            drem <= '0;
            quot <= '0;
            if (kc == 2'd2) begin
              kc    <= '0;
              state <= S_NL;
            end else begin
              kc  <= kc + 2'd1;
              num <= div_num(mag[kc + 2'd1], len);
            end
          end
        end
        S_NL: begin
          nl <= nl + NL_W'(nl_prod);
          if (kc == 2'd2) begin
            state <= S_DONE;
          end else begin
            kc <= kc + 2'd1;
          end
        end
        S_DONE: begin
          if (emit_free) begin
            emit_busy <= 1'b1;
            ecnt      <= '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && emit_free) begin
      for (int k = 0; k < 3; k++) el[k] <= lv[k];
      enl  <= nl;
      edir <= dir;
    end
  end

  // entry pipeline
  logic               v1, v2, v3;
  logic [3:0]         idx1, idx2, idx3;
  logic signed [31:0] a1, b1;
  logic signed [NL_W-1:0] nl1, nl2;
  logic signed [ACC_W-1:0] add1, add2, acc3;
  logic signed [63:0] prod2;

  logic [1:0]              er, ec;
  logic signed [ACC_W-1:0] pshift_r, pshift_d;
  assign er       = ecnt[3:2];
  assign ec       = ecnt[1:0];
  assign pshift_r = ACC_W'(plane[er]) <<< FRAC_BITS;
  assign pshift_d = ACC_W'(plane[REG_PLANE_D]) <<< FRAC_BITS;

  logic signed [ACC_W-1:0] rnd;
  logic                    sat_hi, sat_lo;
  assign rnd    = acc3 + (ACC_W'(1) <<< (FRAC_BITS - 1));
  assign sat_hi = !rnd[ACC_W-1] && (|rnd[ACC_W-2:FRAC_BITS+31]);
  assign sat_lo = rnd[ACC_W-1] && !(&rnd[ACC_W-2:FRAC_BITS+31]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= emit_busy;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx1 <= ecnt;
      a1   <= (ec == 2'd3) ? 32'sd0 : el[ec];
      b1   <= plane[er];
      nl1  <= (er == ec) ? enl : '0;
      if (ec != 2'd3) begin
        add1 <= (er == ec && !edir) ? pshift_d : '0;
      end else begin
        add1 <= (er != 2'd3 && !edir) ? -pshift_r : '0;
      end

      idx2  <= idx1;
      prod2 <= a1 * b1;
      nl2   <= nl1;
      add2  <= add1;

      idx3 <= idx2;
      acc3 <= ACC_W'(nl2) + add2 - ACC_W'(prod2);

      entry_index <= idx3;
      last_entry  <= (idx3 == 4'd15);
      saturated   <= sat_hi || sat_lo;
      priority if (sat_hi) begin
        entry_value <= 32'sh7FFF_FFFF;
      end else if (sat_lo) begin
        entry_value <= 32'sh8000_0000;
      end else begin
        entry_value <= rnd[FRAC_BITS+31:FRAC_BITS];
      end
    end
  end

endmodule

[dv/planar_shadow_matrix_tb.sv]
`timescale 1ns / 1ps

module planar_shadow_matrix_tb;
  import psm_pkg::*;

  typedef struct {
    logic [3:0]         idx;
    logic signed [31:0] val;
    logic               sat;
    logic               last;
  } shadow_entry_t;

  localparam logic signed [127:0] ACC_HI = 128'sd1 <<< (31 + FRAC_BITS);
  localparam longint ONE_Q = longint'(1) << FRAC_BITS;

  class shadow_scoreboard;
    logic signed [31:0] plane [4];
    shadow_entry_t      pending [$];
    int                 errors;
    int                 requests;
    int                 entries;
    int                 clamps;

    function new();
      plane[0] = 0;
      plane[1] = 32'sd1 <<< FRAC_BITS;
      plane[2] = 0;
      plane[3] = 0;
      errors = 0;
      requests = 0;
      entries = 0;
      clamps = 0;
    endfunction

    function void write_plane(int i, logic signed [31:0] v);
      plane[i] = v;
    endfunction

    // Expand one light into the sixteen shadow matrix entries
    function void note_request(logic signed [31:0] lx, logic signed [31:0] ly,
                               logic signed [31:0] lz, logic kind);
      longint            l [3];
      longint            p [4];
      longint unsigned   mag [3];
      longint unsigned   mx, s, len, q, bitv, res;
      logic signed [127:0] acc;
      shadow_entry_t     e;
      int                k, r, c;
      l[0] = lx; l[1] = ly; l[2] = lz;
      for (k = 0; k < 4; k++) p[k] = plane[k];
      requests++;
      if (kind) begin
        mx = 0;
        for (k = 0; k < 3; k++) begin
          mag[k] = (l[k] < 0) ? -l[k] : l[k];
          if (mag[k] > mx) mx = mag[k];
        end
        if (mx != 0) begin
          while (mx < (64'd1 << 30)) begin
            mx = mx << 1;
            for (k = 0; k < 3; k++) mag[k] = mag[k] << 1;
          end
          s = 0;
          for (k = 0; k < 3; k++) s += mag[k] * mag[k];
          res = 0;
          bitv = 64'd1 << 62;
          while (bitv > s) bitv = bitv >> 2;
          while (bitv != 0) begin
            if (s >= res + bitv) begin
              s = s - (res + bitv);
              res = (res >> 1) + bitv;
            end else begin
              res = res >> 1;
            end
            bitv = bitv >> 2;
          end
          len = res;
          for (k = 0; k < 3; k++) begin
            q = ((mag[k] << FRAC_BITS) + (len >> 1)) / len;
            l[k] = (l[k] < 0) ? -longint'(q) : longint'(q);
          end
        end
      end
      for (r = 0; r < 4; r++) begin
        for (c = 0; c < 4; c++) begin
          acc = 0;
          if (r == c)
            for (k = 0; k < 3; k++) acc = acc + l[k] * p[k];
          if (c < 3) begin
            acc = acc - l[c] * p[r];
            if (r == c && !kind) acc = acc + p[3] * ONE_Q;
          end else if (r < 3 && !kind) begin
            acc = acc - p[r] * ONE_Q;
          end
          acc = acc + (128'sd1 <<< (FRAC_BITS - 1));
          e.idx = 4'(4 * r + c);
          e.last = (r == 3 && c == 3);
          if (acc >= ACC_HI) begin
            e.val = 32'sh7FFFFFFF;
            e.sat = 1'b1;
          end else if (acc < -ACC_HI) begin
            e.val = 32'sh80000000;
            e.sat = 1'b1;
          end else begin
            e.val = acc[FRAC_BITS +: 32];
            e.sat = 1'b0;
          end
          pending.push_back(e);
        end
      end
    endfunction

    function void check_entry(logic [3:0] idx, logic signed [31:0] val, logic sat,
                              logic last);
      shadow_entry_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected entry idx=%0d value=%h", $time, idx, val);
        errors++;
        return;
      end
      e = pending.pop_front();
      entries++;
      if (sat) clamps++;
      if (idx !== e.idx) begin
        $display("%0t: entry_index expected %0d actual %0d", $time, e.idx, idx);
        errors++;
      end
      if (val !== e.val) begin
        $display("%0t: entry_value[%0d] expected %h actual %h", $time, e.idx, e.val, val);
        errors++;
      end
      if (sat !== e.sat) begin
        $display("%0t: saturated[%0d] expected %b actual %b", $time, e.idx, e.sat, sat);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last_entry[%0d] expected %b actual %b", $time, e.idx, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] light_x;
  logic signed [31:0] light_y;
  logic signed [31:0] light_z;
  logic               light_kind;
  logic               out_valid;
  logic               out_stall;
  logic [3:0]         entry_index;
  logic signed [31:0] entry_value;
  logic               saturated;
  logic               last_entry;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  shadow_scoreboard shadow_sb = new();

  planar_shadow_matrix uut (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [31:0] pick_light();
    int roll;
    roll = $urandom_range(0, 9);
    case (roll)
      0: return 0;
      1: return 32'sh7FFFFFFF;
      2: return 32'sh80000000;
      3, 4: return $signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000;
      default: return $urandom();
    endcase
  endfunction

  task automatic write_reg(logic [1:0] sel, logic signed [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    shadow_sb.write_plane(sel, v);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_plane(logic signed [31:0] a, logic signed [31:0] b,
                           logic signed [31:0] c, logic signed [31:0] d);
    write_reg(REG_PLANE_A, a);
    write_reg(REG_PLANE_B, b);
    write_reg(REG_PLANE_C, c);
    write_reg(REG_PLANE_D, d);
  endtask

  task automatic send_light(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z, logic kind);
    int gap;
    in_valid <= 1'b1;
    light_x <= x;
    light_y <= y;
    light_z <= z;
    light_kind <= kind;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    shadow_sb.note_request(x, y, z, kind);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off until every pending entry has drained
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (shadow_sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_lights(int n);
    for (int i = 0; i < n; i++)
      send_light(pick_light(), pick_light(), pick_light(), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int roll, n;
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(20, 120)) @(posedge clk);
      end else if (roll < 90) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 3);
        repeat (n - 1) @(posedge clk);
        @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(10, 40)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      shadow_sb.check_entry(entry_index, entry_value, saturated, last_entry);
  end

  initial begin
    #8ms;
    $display("timeout with %0d entries pending", shadow_sb.pending.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    light_x = 0;
    light_y = 0;
    light_z = 0;
    light_kind = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 0;
    pwdata = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset plane, zero and extreme lights, both kinds
    send_light(0, 0, 0, 1'b0);
    send_light(0, 0, 0, 1'b1);
    send_light(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0);
    send_light(32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0);
    send_light(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b1);
    send_light(32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b1);
    send_light(32'sh80000000, 0, 0, 1'b1);
    send_light(1, 0, 0, 1'b1);
    send_light(0, -1, 0, 1'b1);
    send_light(1, 1, 1, 1'b1);
    send_light(32'sh10000, 32'sh40000, -32'sh20000, 1'b0);
    send_light(32'sh10000, 32'sh40000, -32'sh20000, 1'b1);
    send_light(0, 0, 32'sh7FFFFFFF, 1'b1);
    drain();

    set_plane(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_light(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0);
    send_light(32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0);
    send_light(32'sh80000000, 5, -7, 1'b1);
    drain();
    set_plane(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_light(32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0);
    send_light(0, 0, 0, 1'b0);
    send_light(3, -32'sh7FFFFFFF, 9, 1'b1);
    random_lights(90);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_plane($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000,
                     $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000,
                     $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000,
                     $signed($urandom_range(0, 32'hFFFFF)) - 32'sh80000);
        1: set_plane($urandom(), $urandom(), $urandom(), $urandom());
        2: set_plane(0, 0, 0, 0);
        3: set_plane(32'sh7FFFFFFF, 32'sh80000000, 0, 32'sh10000);
        4: set_plane(0, 32'sh10000, 0, -32'sh50000);
        default: set_plane($urandom(), 32'sh10000, $urandom(), 0);
      endcase
      random_lights(30);
      if (ph == 1) drain();
      random_lights(30);
      drain();
    end

    $display("%0d lights, %0d matrix entries checked, %0d clamped",
             shadow_sb.requests, shadow_sb.entries, shadow_sb.clamps);
    $display("plane settings: reset, both extremes, zero and random");
    if (shadow_sb.errors == 0 && shadow_sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d errors, %0d entries missing", shadow_sb.errors,
               shadow_sb.pending.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
hdl/psm_pkg.sv
hdl/planar_shadow_matrix.sv
dv/planar_shadow_matrix_tb.sv
